// ===== rtl/core/hete_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hete_pkg
// Shared widths, types and the arctangent table for the heading error block.
// ----------------------------------------------------------------------------
package hete_pkg;

    // unscaled vector width and scaled datapath widths
    localparam int VW          = 18;
    localparam int SCALE       = 24;
    localparam int XW          = 44;
    localparam int ZW          = 26;
    localparam int EW          = 27;
    localparam int MAX_STAGES  = 24;
    localparam int ATAN_STAGES_DEF = 16;
    localparam int THR_RESET   = 15;

    // atan(2^-i) in degrees, Q.16
    localparam logic signed [ZW-1:0] ATAN_TAB [MAX_STAGES] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    // one vectoring lane
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    // side information that travels with each item
    typedef struct packed {
        logic ok;
        logic flip;
    } t_side;

endpackage

// ===== rtl/core/hete_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hete_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface hete_in_if;
    logic                valid;
    logic                ready;
    logic                tracking_valid;
    logic        [15:0]  robot_x;
    logic        [15:0]  robot_y;
    logic signed [15:0]  heading_x;
    logic signed [15:0]  heading_y;
    logic signed [15:0]  motion_x;
    logic signed [15:0]  motion_y;
    logic        [15:0]  goal_x;
    logic        [15:0]  goal_y;

    modport source (output valid, tracking_valid, robot_x, robot_y, heading_x, heading_y,
                    motion_x, motion_y, goal_x, goal_y, input ready);
    modport sink   (input valid, tracking_valid, robot_x, robot_y, heading_x, heading_y,
                    motion_x, motion_y, goal_x, goal_y, output ready);
endinterface

interface hete_out_if;
    logic                valid;
    logic                ready;
    logic                error_valid;
    logic signed [15:0]  angle_error;
    logic                heading_flipped;
    logic                is_facing;

    modport source (output valid, error_valid, angle_error, heading_flipped, is_facing,
                    input ready);
    modport sink   (input valid, error_valid, angle_error, heading_flipped, is_facing,
                    output ready);
endinterface

// ===== rtl/core/hete_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hete_front
// Offset, dot product, heading flip and quadrant pre-rotation (3 stages).
// ----------------------------------------------------------------------------
module hete_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_tracking_valid,
    input  logic        [15:0]   i_robot_x,
    input  logic        [15:0]   i_robot_y,
    input  logic signed [15:0]   i_heading_x,
    input  logic signed [15:0]   i_heading_y,
    input  logic signed [15:0]   i_motion_x,
    input  logic signed [15:0]   i_motion_y,
    input  logic        [15:0]   i_goal_x,
    input  logic        [15:0]   i_goal_y,
    output logic                 o_valid,
    output hete_pkg::t_vec       o_tgt,
    output hete_pkg::t_vec       o_hdg,
    output hete_pkg::t_side      o_side
);
    import hete_pkg::*;

    // quadrant pre-rotation and scaling
    function automatic t_vec prerot(input logic signed [VW-1:0] y, input logic signed [VW-1:0] x);
        t_vec                  v;
        logic signed [VW-1:0]  xr;
        logic signed [VW-1:0]  yr;
        logic signed [ZW-1:0]  zr;
        xr = x;
        yr = y;
        zr = '0;
        if (x < 0) begin
            if (y >= 0) begin
                xr = y;
                yr = -x;
                zr = ZW'(90 * 65536);
            end else begin
                xr = -y;
                yr = x;
                zr = -(ZW'(90 * 65536));
            end
        end
        v.x = XW'(xr) <<< SCALE;
        v.y = XW'(yr) <<< SCALE;
        v.z = zr;
        return v;
    endfunction

    logic signed [16:0] n1_dx, n1_dy;
    logic signed [16:0] r1_dx, r1_dy;
    logic signed [15:0] r1_hx, r1_hy, r1_mx, r1_my;
    logic               r1_ok, r1_mnz, r1_v;
    logic signed [16:0] r2_dx, r2_dy;
    logic signed [15:0] r2_hx, r2_hy;
    logic signed [31:0] r2_p1, r2_p2;
    logic               r2_ok, r2_mnz, r2_v;
    logic signed [32:0] n3_dot;
    logic               n3_flip;
    logic signed [VW-1:0] n3_hx, n3_hy;
    t_vec               r3_tgt, r3_hdg;
    t_side              r3_side;
    logic               r3_v;

    // stage 1: target offset
    always_comb begin
        n1_dx = $signed({1'b0, i_goal_x}) - $signed({1'b0, i_robot_x});
        n1_dy = $signed({1'b0, i_goal_y}) - $signed({1'b0, i_robot_y});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx  <= n1_dx;
            r1_dy  <= n1_dy;
            r1_hx  <= i_heading_x;
            r1_hy  <= i_heading_y;
            r1_mx  <= i_motion_x;
            r1_my  <= i_motion_y;
            r1_ok  <= i_tracking_valid && (n1_dx != 0 || n1_dy != 0);
            r1_mnz <= (i_motion_x != 0) || (i_motion_y != 0);
        end
    end

    // stage 2: dot product terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p1  <= r1_hx * r1_mx;
            r2_p2  <= r1_hy * r1_my;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_hx  <= r1_hx;
            r2_hy  <= r1_hy;
            r2_ok  <= r1_ok;
            r2_mnz <= r1_mnz;
        end
    end

    // stage 3: flip test and pre-rotation of both lanes
    always_comb begin
        n3_dot  = 33'(r2_p1) + 33'(r2_p2);
        n3_flip = r2_ok && r2_mnz && (n3_dot < -(33'sd1 <<< 27));
        n3_hx   = n3_flip ? -VW'(r2_hx) : VW'(r2_hx);
        n3_hy   = n3_flip ? -VW'(r2_hy) : VW'(r2_hy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tgt       <= prerot(VW'(r2_dy), VW'(r2_dx));
            r3_hdg       <= prerot(n3_hy, n3_hx);
            r3_side.ok   <= r2_ok;
            r3_side.flip <= n3_flip;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    assign o_valid = r3_v;
    assign o_tgt   = r3_tgt;
    assign o_hdg   = r3_hdg;
    assign o_side  = r3_side;
endmodule

// ===== rtl/core/hete_cordic_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hete_cordic_stage
// One registered vectoring rotation of a single lane.
// ----------------------------------------------------------------------------
module hete_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  hete_pkg::t_vec  i_vec,
    output hete_pkg::t_vec  o_vec
);
    import hete_pkg::*;

    logic signed [XW-1:0] n_xs, n_ys;
    t_vec                 n_vec, r_vec;

    // rotate towards the x axis
    always_comb begin
        n_xs  = i_vec.x >>> IDX;
        n_ys  = i_vec.y >>> IDX;
        n_vec = i_vec;
        if (i_vec.y > 0) begin
            n_vec.x = i_vec.x + n_ys;
            n_vec.y = i_vec.y - n_xs;
            n_vec.z = i_vec.z + ATAN_TAB[IDX];
        end else if (i_vec.y < 0) begin
            n_vec.x = i_vec.x - n_ys;
            n_vec.y = i_vec.y + n_xs;
            n_vec.z = i_vec.z - ATAN_TAB[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;
endmodule

// ===== rtl/core/hete_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hete_back
// Angle difference, wrap, rounding to Q8.7 and facing test (2 stages).
// ----------------------------------------------------------------------------
module hete_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [hete_pkg::ZW-1:0] i_z_tgt,
    input  logic signed [hete_pkg::ZW-1:0] i_z_hdg,
    input  hete_pkg::t_side      i_side,
    input  logic        [7:0]    i_thr,
    output logic                 o_valid,
    output logic                 o_error_valid,
    output logic signed [15:0]   o_angle_error,
    output logic                 o_heading_flipped,
    output logic                 o_is_facing
);
    import hete_pkg::*;

    localparam logic signed [EW-1:0] HALF = EW'(180 * 65536);
    localparam logic signed [EW-1:0] FULL = EW'(360 * 65536);

    logic signed [EW-1:0] n_err, r_err;
    t_side                r_side;
    logic                 r_v1;
    logic signed [EW-1:0] n_rnd;
    logic signed [15:0]   n_q;
    logic        [15:0]   n_mag;
    logic                 r_v2, r_ev, r_flip, r_face;
    logic signed [15:0]   r_q;

    // difference wrapped once by a full turn
    always_comb begin
        n_err = EW'(i_z_tgt) - EW'(i_z_hdg);
        if (n_err > HALF) begin
            n_err = n_err - FULL;
        end else if (n_err < -HALF) begin
            n_err = n_err + FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err  <= n_err;
            r_side <= i_side;
        end
    end

    // round to Q8.7 and compare magnitude
    always_comb begin
        n_rnd = (r_err + EW'(256)) >>> 9;
        n_q   = n_rnd[15:0];
        n_mag = n_q[15] ? 16'(-n_q) : 16'(n_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ev   <= r_side.ok;
            r_q    <= r_side.ok ? n_q : 16'sd0;
            r_flip <= r_side.ok && r_side.flip;
            r_face <= r_side.ok && ({1'b0, n_mag} <= {2'b0, i_thr, 7'b0});
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid           = r_v2;
    assign o_error_valid     = r_ev;
    assign o_angle_error     = r_q;
    assign o_heading_flipped = r_flip;
    assign o_is_facing       = r_face;
endmodule

// ===== rtl/core/heading_error_to_target_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_error_to_target_core
// Bearing error from robot heading to a target point, wrapped to +-180 deg.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output is taken (3 front stages,
// one register per CORDIC rotation for the target and heading lanes side by side,
// 2 back stages). The whole pipe advances together and holds while a result sits
// in the output register untaken.
module heading_error_to_target_core #(
    parameter int ATAN_STAGES = hete_pkg::ATAN_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    hete_in_if.sink     i_in,
    hete_out_if.source  o_out
);
    import hete_pkg::*;

    logic        en;
    logic [7:0]  r_thr;
    logic        front_v;
    t_vec        front_tgt, front_hdg;
    t_side       front_side;
    t_vec        tgt_pipe [ATAN_STAGES+1];
    t_vec        hdg_pipe [ATAN_STAGES+1];
    logic        r_v    [ATAN_STAGES];
    t_side       r_side [ATAN_STAGES];

    // pipe advances unless the output holds an untaken result
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 8'(THR_RESET);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    hete_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_in.valid),
        .i_tracking_valid (i_in.tracking_valid),
        .i_robot_x        (i_in.robot_x),
        .i_robot_y        (i_in.robot_y),
        .i_heading_x      (i_in.heading_x),
        .i_heading_y      (i_in.heading_y),
        .i_motion_x       (i_in.motion_x),
        .i_motion_y       (i_in.motion_y),
        .i_goal_x         (i_in.goal_x),
        .i_goal_y         (i_in.goal_y),
        .o_valid          (front_v),
        .o_tgt            (front_tgt),
        .o_hdg            (front_hdg),
        .o_side           (front_side)
    );

    assign tgt_pipe[0] = front_tgt;
    assign hdg_pipe[0] = front_hdg;

    // cordic rotations, both lanes per stage
    for (genvar g = 0; g < ATAN_STAGES; g++) begin : g_rot
        hete_cordic_stage #(.IDX(g)) u_tgt (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (tgt_pipe[g]),
            .o_vec (tgt_pipe[g+1])
        );
        hete_cordic_stage #(.IDX(g)) u_hdg (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (hdg_pipe[g]),
            .o_vec (hdg_pipe[g+1])
        );

        // side info and valid travel alongside
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[g] <= (g == 0) ? front_side : r_side[(g == 0) ? 0 : g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (en) begin
                r_v[g] <= (g == 0) ? front_v : r_v[(g == 0) ? 0 : g-1];
            end
        end
    end

    hete_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (r_v[ATAN_STAGES-1]),
        .i_z_tgt           (tgt_pipe[ATAN_STAGES].z),
        .i_z_hdg           (hdg_pipe[ATAN_STAGES].z),
        .i_side            (r_side[ATAN_STAGES-1]),
        .i_thr             (r_thr),
        .o_valid           (o_out.valid),
        .o_error_valid     (o_out.error_valid),
        .o_angle_error     (o_out.angle_error),
        .o_heading_flipped (o_out.heading_flipped),
        .o_is_facing       (o_out.is_facing)
    );

    // invalid results carry all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.error_valid) |->
            (o_out.angle_error == 16'sd0 && !o_out.is_facing && !o_out.heading_flipped))
        else $error("invalid result with nonzero fields");

    // facing only on defined errors
    a_facing_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_facing) |-> o_out.error_valid)
        else $error("facing flag without a defined error");

    // wrapped error stays within a half turn
    a_error_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_valid) |->
            (o_out.angle_error <= 16'sd23040 && o_out.angle_error >= -16'sd23040))
        else $error("angle error outside +-180 degrees");
endmodule

// ===== sim/heading_error_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_error_checker
// Watches the input and result channels of the heading error block, computes
// the expected bearing error of every accepted item and compares each result
// transfer field by field in order.
// ----------------------------------------------------------------------------
module heading_error_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    hete_in_if.sink     i_in,
    hete_out_if.sink    i_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_flip_count,
    output int          o_facing_count
);
    import hete_pkg::*;

    typedef struct packed {
        logic               error_valid;
        logic signed [15:0] angle_error;
        logic               heading_flipped;
        logic               is_facing;
    } t_bearing;

    localparam int STAGES = ATAN_STAGES_DEF;

    t_bearing    bearing_q[$];
    logic [7:0]  facing_thr;

    // floor shift right on a 64-bit signed value
    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    // vectoring arctangent in Q.16 degrees, zero vector gives 0
    function automatic longint vector_angle(longint vy, longint vx);
        longint ax, ay, az, xs, ys, t;
        ax = vx <<< SCALE;
        ay = vy <<< SCALE;
        az = 0;
        if (ax < 0) begin
            if (ay >= 0) begin
                t = ax; ax = ay; ay = -t; az = 90 * 65536;
            end else begin
                t = ax; ax = -ay; ay = t; az = -90 * 65536;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = asr(ax, i);
            ys = asr(ay, i);
            if (ay > 0) begin
                ax = ax + ys; ay = ay - xs; az += longint'(ATAN_TAB[i]);
            end else if (ay < 0) begin
                ax = ax - ys; ay = ay + xs; az -= longint'(ATAN_TAB[i]);
            end
        end
        return az;
    endfunction

    function automatic t_bearing bearing_error(
        logic tv, logic [15:0] rx, logic [15:0] ry,
        logic signed [15:0] hx16, logic signed [15:0] hy16,
        logic signed [15:0] mx16, logic signed [15:0] my16,
        logic [15:0] tx, logic [15:0] ty, logic [7:0] thr);
        t_bearing r;
        longint dx, dy, hx, hy, mx, my, dot, err, q, mag;
        logic flip;
        r = '0;
        dx = longint'(tx) - longint'(rx);
        dy = longint'(ty) - longint'(ry);
        hx = hx16; hy = hy16; mx = mx16; my = my16;
        if (!tv || (dx == 0 && dy == 0)) return r;
        dot = hx * mx + hy * my;
        flip = (mx != 0 || my != 0) && dot < -(longint'(1) <<< 27);
        if (flip) begin
            hx = -hx; hy = -hy;
        end
        err = vector_angle(dy, dx) - vector_angle(hy, hx);
        if (err > 180 * 65536) err -= 360 * 65536;
        else if (err < -180 * 65536) err += 360 * 65536;
        q = asr(err + 256, 9);
        mag = q < 0 ? -q : q;
        r.error_valid = 1'b1;
        r.angle_error = q[15:0];
        r.heading_flipped = flip;
        r.is_facing = mag <= longint'(thr) * 128;
        return r;
    endfunction

    assign o_pending = bearing_q.size();

    // track register, predict on input transfer, compare on result transfer
    always @(posedge i_clk) begin
        t_bearing got, want;
        if (!i_rst_n) begin
            facing_thr <= 8'(THR_RESET);
            o_fail_count <= 0;
            o_result_count <= 0;
            o_flip_count <= 0;
            o_facing_count <= 0;
        end else begin
            if (i_cfg_we) facing_thr <= i_cfg_data;
            if (i_in.valid && i_in.ready) begin
                bearing_q.push_back(bearing_error(i_in.tracking_valid, i_in.robot_x,
                    i_in.robot_y, i_in.heading_x, i_in.heading_y, i_in.motion_x,
                    i_in.motion_y, i_in.goal_x, i_in.goal_y, facing_thr));
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.error_valid, i_out.angle_error, i_out.heading_flipped,
                        i_out.is_facing};
                o_result_count <= o_result_count + 1;
                if (bearing_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = bearing_q.pop_front();
                    if (got.heading_flipped) o_flip_count <= o_flip_count + 1;
                    if (got.is_facing) o_facing_count <= o_facing_count + 1;
                    if (got != want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.error_valid != want.error_valid)
                            $error("error_valid expected %0d got %0d",
                                   want.error_valid, got.error_valid);
                        if (got.angle_error != want.angle_error)
                            $error("angle_error expected %0d got %0d",
                                   want.angle_error, got.angle_error);
                        if (got.heading_flipped != want.heading_flipped)
                            $error("heading_flipped expected %0d got %0d",
                                   want.heading_flipped, got.heading_flipped);
                        if (got.is_facing != want.is_facing)
                            $error("is_facing expected %0d got %0d",
                                   want.is_facing, got.is_facing);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_heading_error_to_target_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_error_to_target_core
// Drives directed and random robot/target items through the heading error
// block under several facing thresholds, with random idling on both sides and
// a long result stall; the checker compares every result with its prediction.
// ----------------------------------------------------------------------------
module tb_heading_error_to_target_core;
    import hete_pkg::*;

    localparam int LATENCY = ATAN_STAGES_DEF + 5;
    localparam int N_RANDOM = 1700;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    int         fail_count, pending, result_count, flip_count, facing_count;
    logic       quiet_tail;
    logic       hold_results;
    int         sent_count;

    hete_in_if  in_ch();
    hete_out_if out_ch();

    heading_error_to_target_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    heading_error_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in           (in_ch.sink),
        .i_out          (out_ch.sink),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_flip_count   (flip_count),
        .o_facing_count (facing_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("heading_error_to_target_core: mismatch");
        $finish;
    end

    // result side ready with random stall bursts and one long hold-off
    initial begin
        int   gap;
        logic hold_done;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_results && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_done = 1'b1;
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 15);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // one input transfer, with an optional idle burst ahead of it
    task automatic send_item(logic tv, logic [15:0] rx, logic [15:0] ry,
                             logic [15:0] hx, logic [15:0] hy, logic [15:0] mx,
                             logic [15:0] my, logic [15:0] tx, logic [15:0] ty);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.tracking_valid <= tv;
        in_ch.robot_x        <= rx;
        in_ch.robot_y        <= ry;
        in_ch.heading_x      <= hx;
        in_ch.heading_y      <= hy;
        in_ch.motion_x       <= mx;
        in_ch.motion_y       <= my;
        in_ch.goal_x         <= tx;
        in_ch.goal_y         <= ty;
        @(posedge i_clk iff in_ch.ready);
        sent_count++;
    endtask

    // random item: unit-ish vectors from an angle in tenths of a degree, Q2.14, or raw random words
    task automatic send_random();
        logic [15:0] rx, ry, tx, ty, hx, hy, mx, my;
        real a, b;
        int mode;
        mode = $urandom_range(0, 9);
        rx = 16'($urandom); ry = 16'($urandom);
        if (mode < 6) begin
            // nearby target, realistic unit vectors, motion often opposite
            tx = rx + 16'($signed($urandom_range(0, 4000)) - 2000);
            ty = ry + 16'($signed($urandom_range(0, 4000)) - 2000);
            a = $urandom_range(0, 3599) * 3.14159265 / 1800.0;
            b = ($urandom_range(0, 1) ? a + 3.14159265 : a)
                + ($signed($urandom_range(0, 200)) - 100) * 0.01;
            hx = 16'($rtoi(16384.0 * $cos(a)));
            hy = 16'($rtoi(16384.0 * $sin(a)));
            mx = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($rtoi(16384.0 * $cos(b)));
            my = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($rtoi(16384.0 * $sin(b)));
        end else begin
            tx = $urandom_range(0, 7) == 0 ? rx : 16'($urandom);
            ty = $urandom_range(0, 7) == 0 ? ry : 16'($urandom);
            hx = 16'($urandom); hy = 16'($urandom);
            mx = 16'($urandom); my = 16'($urandom);
        end
        send_item($urandom_range(0, 15) != 0, rx, ry, hx, hy, mx, my, tx, ty);
    endtask

    // wait for the pipe to drain before touching the threshold
    task automatic drain_and_set(logic [7:0] thr);
        in_ch.valid <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        logic [7:0] thr_list [6] = '{8'd0, 8'd180, 8'd255, 8'd1, 8'd90, 8'd15};
        sent_count   = 0;
        quiet_tail   = 1'b0;
        hold_results = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 8'd0;
        in_ch.valid  = 1'b0;
        in_ch.tracking_valid = 1'b0;
        in_ch.robot_x = '0; in_ch.robot_y = '0;
        in_ch.heading_x = '0; in_ch.heading_y = '0;
        in_ch.motion_x = '0; in_ch.motion_y = '0;
        in_ch.goal_x = '0; in_ch.goal_y = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: untracked, target on robot, zero heading, flips, extremes
        send_item(1'b0, 16'd100, 16'd100, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                  16'd200, 16'd100);
        send_item(1'b1, 16'd500, 16'd500, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                  16'd500, 16'd500);
        send_item(1'b1, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  16'd1000, 16'd1000);
        send_item(1'b1, 16'd0, 16'd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0,
                  16'd160, 16'd0);
        send_item(1'b1, 16'd0, 16'd0, 16'sd16384, 16'sd0, -16'sd8192, 16'sd0,
                  16'd160, 16'd0);
        send_item(1'b1, 16'd0, 16'd0, 16'sd16384, 16'sd0, -16'sd8193, 16'sd0,
                  16'd160, 16'd0);
        send_item(1'b1, 16'd0, 16'd0, -16'sd32768, -16'sd32768, -16'sd32768,
                  -16'sd32768, 16'd65535, 16'd65535);
        send_item(1'b1, 16'd65535, 16'd65535, 16'sd32767, 16'sd32767, 16'sd32767,
                  16'sd32767, 16'd0, 16'd0);
        send_item(1'b1, 16'd1000, 16'd1000, -16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                  16'd0, 16'd1000);
        send_item(1'b1, 16'd1000, 16'd1000, -16'sd16384, 16'sd1, 16'sd0, 16'sd0,
                  16'd0, 16'd999);
        send_item(1'b1, 16'd1000, 16'd1000, -16'sd16384, -16'sd1, 16'sd0, 16'sd0,
                  16'd0, 16'd1001);
        send_item(1'b1, 16'd1000, 16'd1000, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
                  16'd1000, 16'd0);
        send_item(1'b1, 16'd0, 16'd65535, 16'sd0, -16'sd16384, 16'sd0, 16'sd1,
                  16'd65535, 16'd0);
        send_item(1'b1, 16'd1000, 16'd1000, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                  16'd1001, 16'd1000);

        // random items across thresholds including the extremes
        for (int p = 0; p < 6; p++) begin
            drain_and_set(thr_list[p]);
            if (p == 1) hold_results <= 1'b1;
            if (p == 5) quiet_tail <= 1'b1;
            for (int k = 0; k < N_RANDOM / 6; k++) send_random();
        end
        in_ch.valid <= 1'b0;

        // drain
        fork
            @(posedge i_clk iff pending == 0);
            begin
                repeat (200000) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("covered %0d items, %0d results, %0d flipped, %0d facing, 6 thresholds",
                 sent_count, result_count, flip_count, facing_count);
        if (fail_count == 0 && pending == 0)
            $display("heading_error_to_target_core: match");
        else
            $display("heading_error_to_target_core: mismatch");
        $finish;
    end

endmodule
